FILE: sv/pdr_pkg.sv
// Package for the packet descriptor ring: action, status and step codes,
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pdr_pkg;

  localparam int DEPTH_DEF       = 32;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF = 16;

  // Fixed widths of the drop count, byte total and entry count fields.
  localparam int TOTAL_W = 21;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_PEEK  = 3'd1,
    ACT_POP   = 3'd2,
    ACT_DROP  = 3'd3,
    ACT_FLUSH = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What the datapath does with the head slot and the indices on one result.
  typedef enum logic [2:0] {
    STEP_NOP,
    STEP_PUSH,
    STEP_PUSH_FULL,
    STEP_HEAD,
    STEP_EMPTY,
    STEP_POP,
    STEP_TRIM,
    STEP_FREE
  } step_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic  accept;
    logic  rd_en;
    logic  exec;
    step_t step;
    logic  last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       empty;
    logic       full;
    logic       remain_zero;
    logic       len_gt;
    logic       rem_eq_len;
    logic       last_slot;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: sv/pdr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on pdr_pkg for its default widths.
`timescale 1ns / 1ps

module pdr_ram #(
  parameter int WIDTH = pdr_pkg::HANDLE_BITS_DEF,
  parameter int DEPTH = pdr_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/pdr_ctrl.sv
// Controller state machine for the descriptor ring: sequences accept,
// head reads and result steps. Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdr_pkg::dp_stat_t   stat,
  output pdr_pkg::ctrl_cmd_t  cmd
);

  pdr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.exec   = 1'b0;
    cmd.step   = pdr_pkg::STEP_NOP;
    cmd.last   = 1'b1;
    unique case (state_r)
      pdr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.rd_en  = 1'b1;
          state_nxt  = pdr_pkg::S_EXEC;
        end
      end
      pdr_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = pdr_pkg::S_EXEC;
      end
      pdr_pkg::S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec = 1'b1;
          case (pdr_pkg::action_t'(stat.action))
            pdr_pkg::ACT_PUSH: begin
              cmd.step = stat.full ? pdr_pkg::STEP_PUSH_FULL : pdr_pkg::STEP_PUSH;
            end
            pdr_pkg::ACT_PEEK: begin
              cmd.step = stat.empty ? pdr_pkg::STEP_EMPTY : pdr_pkg::STEP_HEAD;
            end
            pdr_pkg::ACT_POP: begin
              cmd.step = stat.empty ? pdr_pkg::STEP_EMPTY : pdr_pkg::STEP_POP;
            end
            pdr_pkg::ACT_DROP: begin
              // The loop only carries on with bytes left and a head present,
              // so the empty or zero case is always the first result.
              if (stat.empty) begin
                cmd.step = pdr_pkg::STEP_EMPTY;
              end else if (stat.remain_zero) begin
                cmd.step = pdr_pkg::STEP_HEAD;
              end else if (stat.len_gt) begin
                cmd.step = pdr_pkg::STEP_TRIM;
              end else begin
                cmd.step = pdr_pkg::STEP_FREE;
                cmd.last = stat.rem_eq_len || stat.last_slot;
              end
            end
            pdr_pkg::ACT_FLUSH: begin
              if (stat.empty) begin
                cmd.step = pdr_pkg::STEP_EMPTY;
              end else begin
                cmd.step = pdr_pkg::STEP_FREE;
                cmd.last = stat.last_slot;
              end
            end
            default: begin
              cmd.step = pdr_pkg::STEP_NOP;
            end
          endcase
          state_nxt = cmd.last ? pdr_pkg::S_IDLE : pdr_pkg::S_READ;
        end
      end
      default: begin
        state_nxt = pdr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/pdr_dp.sv
// Datapath of the descriptor ring: handle and length stores, ring indices,
// byte total, drop remainder and the result register. Depends on pdr_pkg
// and pdr_ram.
`timescale 1ns / 1ps

module pdr_dp #(
  parameter int DEPTH       = pdr_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = pdr_pkg::HANDLE_BITS_DEF,
  parameter int LENGTH_BITS = pdr_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [2:0]                   in_action,
  input  logic [HANDLE_BITS-1:0]       in_handle_in,
  input  logic [LENGTH_BITS-1:0]       in_length_in,
  input  logic [pdr_pkg::TOTAL_W-1:0]  in_drop_count,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [HANDLE_BITS-1:0]       out_handle_out,
  output logic [LENGTH_BITS-1:0]       out_length_out,
  output logic                         out_freed,
  output logic [pdr_pkg::TOTAL_W-1:0]  out_byte_total,
  output logic [pdr_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                         out_last,
  input  pdr_pkg::ctrl_cmd_t           cmd,
  output pdr_pkg::dp_stat_t            stat
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int TW    = pdr_pkg::TOTAL_W;
  localparam int CMP_W = (LENGTH_BITS > TW) ? LENGTH_BITS : TW;
  localparam int CNT_W = (IDX_W + 1 > pdr_pkg::COUNT_W) ? IDX_W + 1 : pdr_pkg::COUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [2:0]             action_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [LENGTH_BITS-1:0] length_r;
  logic [TW-1:0]          remain_r, remain_nxt;
  logic [IDX_W-1:0]       wi_r, wi_nxt, ri_r, ri_nxt;
  logic [TW-1:0]          stored_r, stored_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [HANDLE_BITS-1:0] handle_out_r, handle_out_nxt;
  logic [LENGTH_BITS-1:0] length_out_r, length_out_nxt;
  logic                   freed_r, freed_nxt;
  logic [TW-1:0]          total_r;
  logic [pdr_pkg::COUNT_W-1:0] count_r;
  logic                   last_r;

  logic [HANDLE_BITS-1:0] rd_handle;
  logic [LENGTH_BITS-1:0] rd_length;
  logic                   h_wr_en, l_wr_en;
  logic [IDX_W-1:0]       l_wr_addr;
  logic [LENGTH_BITS-1:0] l_wr_data;

  logic [IDX_W-1:0]       wi_inc, ri_inc;
  logic [CMP_W-1:0]       len_cmp, rem_cmp, trim_cmp, lin_cmp;
  logic [LENGTH_BITS-1:0] trim_len;
  logic [IDX_W:0]         diff;
  logic [CNT_W-1:0]       count_w;

  pdr_ram #(.WIDTH(HANDLE_BITS), .DEPTH(DEPTH)) u_handle_ram (
    .clk     (clk),
    .wr_en   (h_wr_en),
    .wr_addr (wi_r),
    .wr_data (handle_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (ri_r),
    .rd_data (rd_handle)
  );

  pdr_ram #(.WIDTH(LENGTH_BITS), .DEPTH(DEPTH)) u_length_ram (
    .clk     (clk),
    .wr_en   (l_wr_en),
    .wr_addr (l_wr_addr),
    .wr_data (l_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ri_r),
    .rd_data (rd_length)
  );

  assign wi_inc = (wi_r == LAST_IDX) ? '0 : wi_r + 1'b1;
  assign ri_inc = (ri_r == LAST_IDX) ? '0 : ri_r + 1'b1;

  assign len_cmp  = CMP_W'(rd_length);
  assign rem_cmp  = CMP_W'(remain_r);
  assign lin_cmp  = CMP_W'(length_r);
  assign trim_cmp = len_cmp - rem_cmp;
  assign trim_len = trim_cmp[LENGTH_BITS-1:0];

  assign stat.action      = action_r;
  assign stat.empty       = (ri_r == wi_r);
  assign stat.full        = (wi_inc == ri_r);
  assign stat.remain_zero = (remain_r == '0);
  assign stat.len_gt      = (len_cmp > rem_cmp);
  assign stat.rem_eq_len  = (len_cmp == rem_cmp);
  assign stat.last_slot   = (ri_inc == wi_r);
  assign stat.out_free    = !out_valid_r || out_ready;

  always_comb begin
    wi_nxt         = wi_r;
    ri_nxt         = ri_r;
    stored_nxt     = stored_r;
    remain_nxt     = remain_r;
    h_wr_en        = 1'b0;
    l_wr_en        = 1'b0;
    l_wr_addr      = wi_r;
    l_wr_data      = length_r;
    status_nxt     = pdr_pkg::ST_OK;
    handle_out_nxt = '0;
    length_out_nxt = '0;
    freed_nxt      = 1'b0;
    if (cmd.exec) begin
      case (cmd.step)
        pdr_pkg::STEP_PUSH: begin
          h_wr_en        = 1'b1;
          l_wr_en        = 1'b1;
          wi_nxt         = wi_inc;
          stored_nxt     = stored_r + lin_cmp[TW-1:0];
          handle_out_nxt = handle_r;
          length_out_nxt = length_r;
        end
        pdr_pkg::STEP_PUSH_FULL: begin
          status_nxt     = pdr_pkg::ST_FULL;
          handle_out_nxt = handle_r;
          length_out_nxt = length_r;
          freed_nxt      = 1'b1;
        end
        pdr_pkg::STEP_HEAD: begin
          handle_out_nxt = rd_handle;
          length_out_nxt = rd_length;
        end
        pdr_pkg::STEP_EMPTY: begin
          status_nxt = pdr_pkg::ST_EMPTY;
        end
        pdr_pkg::STEP_POP: begin
          ri_nxt         = ri_inc;
          stored_nxt     = stored_r - len_cmp[TW-1:0];
          handle_out_nxt = rd_handle;
          length_out_nxt = rd_length;
        end
        pdr_pkg::STEP_TRIM: begin
          l_wr_en        = 1'b1;
          l_wr_addr      = ri_r;
          l_wr_data      = trim_len;
          stored_nxt     = stored_r - remain_r;
          remain_nxt     = '0;
          handle_out_nxt = rd_handle;
          length_out_nxt = trim_len;
        end
        pdr_pkg::STEP_FREE: begin
          // On a flush the remainder is never looked at, so it may wrap.
          ri_nxt         = ri_inc;
          stored_nxt     = stored_r - len_cmp[TW-1:0];
          remain_nxt     = remain_r - len_cmp[TW-1:0];
          handle_out_nxt = rd_handle;
          length_out_nxt = rd_length;
          freed_nxt      = 1'b1;
        end
        default: begin
          status_nxt = pdr_pkg::ST_OK;
        end
      endcase
    end
  end

  // Entry count after this result, from the updated indices.
  always_comb begin
    diff = {1'b0, wi_nxt} - {1'b0, ri_nxt};
    if (wi_nxt < ri_nxt) begin
      diff = diff + (IDX_W + 1)'(DEPTH);
    end
    count_w = CNT_W'(diff);
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r        <= '0;
      ri_r        <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wi_r        <= wi_nxt;
      ri_r        <= ri_nxt;
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      handle_r <= in_handle_in;
      length_r <= in_length_in;
      remain_r <= in_drop_count;
    end else begin
      remain_r <= remain_nxt;
    end
    if (cmd.exec) begin
      status_r     <= status_nxt;
      handle_out_r <= handle_out_nxt;
      length_out_r <= length_out_nxt;
      freed_r      <= freed_nxt;
      total_r      <= stored_nxt;
      count_r      <= count_w[pdr_pkg::COUNT_W-1:0];
      last_r       <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_handle_out  = handle_out_r;
  assign out_length_out  = length_out_r;
  assign out_freed       = freed_r;
  assign out_byte_total  = total_r;
  assign out_entry_count = count_r;
  assign out_last        = last_r;

endmodule

FILE: sv/packet_descriptor_ring_byte_drop_core.sv
// Top level of the packet descriptor ring with byte drop from the front.
// Depends on pdr_pkg, pdr_ctrl, pdr_dp and pdr_ram.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+--------------------------------------------
//   input   | in_valid / in_ready   | action, handle_in, length_in, drop_count
//   result  | out_valid / out_ready | status, handle_out, length_out, freed,
//           |                       | byte_total, entry_count, last
//
// Push, peek, pop and unused codes do a read of the head slot from the stores
// at accept, then the update and the result register load.
// Drop and flush do one head read and one update for each result.
// Reset clears the indices and byte total; the stores are not cleared, as
// only slots that have been written are ever used.
// A stalled result register holds the step in progress until it is taken.
`timescale 1ns / 1ps

module packet_descriptor_ring_byte_drop_core #(
  parameter int DEPTH       = pdr_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = pdr_pkg::HANDLE_BITS_DEF,
  parameter int LENGTH_BITS = pdr_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_action,
  input  logic [HANDLE_BITS-1:0]       in_handle_in,
  input  logic [LENGTH_BITS-1:0]       in_length_in,
  input  logic [pdr_pkg::TOTAL_W-1:0]  in_drop_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [HANDLE_BITS-1:0]       out_handle_out,
  output logic [LENGTH_BITS-1:0]       out_length_out,
  output logic                         out_freed,
  output logic [pdr_pkg::TOTAL_W-1:0]  out_byte_total,
  output logic [pdr_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                         out_last
);

  pdr_pkg::ctrl_cmd_t cmd;
  pdr_pkg::dp_stat_t  stat;

  pdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdr_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_handle_in    (in_handle_in),
    .in_length_in    (in_length_in),
    .in_drop_count   (in_drop_count),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_handle_out  (out_handle_out),
    .out_length_out  (out_length_out),
    .out_freed       (out_freed),
    .out_byte_total  (out_byte_total),
    .out_entry_count (out_entry_count),
    .out_last        (out_last),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
